[src/blsp_pkg.sv]
// shared constants and helpers for the bresenham line stepper
// no dependencies; imported by the front end, back end and top level modules
`default_nettype none

package blsp_pkg;

    // item opcodes on the input channel
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // width of one queued command: op, x_dir, y_dir, steep, four coordinates
    // or lengths, and a decision term two bits wider than a coordinate
    function automatic int cmd_width(input int coord_bits);
        return 5 * coord_bits + 6;
    endfunction

endpackage

`default_nettype wire

[src/blsp_if.sv]
// channel interfaces for the bresenham line stepper
// blsp_in_if carries start and step items, blsp_pix_if carries pixels
`default_nettype none

interface blsp_in_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (output valid, op, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, op, x_start, y_start, x_end, y_end, output ready);
endinterface

interface blsp_pix_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;

    modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

`default_nettype wire

[src/blsp_front.sv]
// front end: takes input beats and classifies them into line commands
// depends on blsp_pkg and blsp_in_if
`default_nettype none

module blsp_front
    import blsp_pkg::*;
#(
    parameter int  COORD_BITS = 12,
    localparam int CMD_W      = cmd_width(COORD_BITS)
) (
    blsp_in_if.sink           i_in,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output logic [CMD_W-1:0]  o_cmd
);

    typedef struct packed {
        logic                  op;
        logic                  x_dir;
        logic                  y_dir;
        logic                  steep;
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] major;
        logic [COORD_BITS-1:0] minor;
        logic [COORD_BITS+1:0] decision;
    } t_cmd;

    t_cmd                  w_cmd;
    logic                  w_x_dir;
    logic                  w_y_dir;
    logic [COORD_BITS-1:0] w_dx;
    logic [COORD_BITS-1:0] w_dy;
    logic                  w_steep;
    logic [COORD_BITS-1:0] w_major;
    logic [COORD_BITS-1:0] w_minor;

    assign w_x_dir = i_in.x_end < i_in.x_start;
    assign w_y_dir = i_in.y_end < i_in.y_start;
    assign w_dx    = w_x_dir ? i_in.x_start - i_in.x_end : i_in.x_end - i_in.x_start;
    assign w_dy    = w_y_dir ? i_in.y_start - i_in.y_end : i_in.y_end - i_in.y_start;
    // 45 degree lines and single points count as steep
    assign w_steep = w_dy >= w_dx;
    assign w_major = w_steep ? w_dy : w_dx;
    assign w_minor = w_steep ? w_dx : w_dy;

    always_comb begin
        w_cmd.op       = i_in.op;
        w_cmd.x_dir    = w_x_dir;
        w_cmd.y_dir    = w_y_dir;
        w_cmd.steep    = w_steep;
        w_cmd.x0       = i_in.x_start;
        w_cmd.y0       = i_in.y_start;
        w_cmd.major    = w_major;
        w_cmd.minor    = w_minor;
        // initial term 2*minor - major
        w_cmd.decision = {1'b0, w_minor, 1'b0} - {2'b00, w_major};
    end

    assign o_cmd       = w_cmd;
    assign o_cmd_valid = i_in.valid;
    assign i_in.ready  = i_cmd_ready;

endmodule

`default_nettype wire

[src/blsp_fifo.sv]
// two-entry command queue between the front end and the stepper
// depends on nothing but its width parameter
`default_nettype none

module blsp_fifo #(
    parameter int WIDTH = 66
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_ready = !r_count[1];
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[src/blsp_back.sv]
// back end: walks the line one major-axis step per command, output register
// depends on blsp_pkg and blsp_pix_if
`default_nettype none

module blsp_back
    import blsp_pkg::*;
#(
    parameter int  COORD_BITS = 12,
    localparam int CMD_W      = cmd_width(COORD_BITS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  logic [CMD_W-1:0]  i_cmd,
    blsp_pix_if.source        o_pix
);

    typedef struct packed {
        logic                  op;
        logic                  x_dir;
        logic                  y_dir;
        logic                  steep;
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] major;
        logic [COORD_BITS-1:0] minor;
        logic [COORD_BITS+1:0] decision;
    } t_cmd;

    localparam int DW = COORD_BITS + 2;

    t_cmd                  w_cmd;
    logic [COORD_BITS-1:0] r_cur_x,     n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y,     n_cur_y;
    logic [DW-1:0]         r_decision,  n_decision;
    logic [COORD_BITS-1:0] r_major,     n_major;
    logic [COORD_BITS-1:0] r_minor,     n_minor;
    logic                  r_x_dir,     n_x_dir;
    logic                  r_y_dir,     n_y_dir;
    logic                  r_steep,     n_steep;
    logic [COORD_BITS-1:0] r_remaining, n_remaining;
    logic                  r_active,    n_active;
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x;
    logic [COORD_BITS-1:0] r_out_y;
    logic                  r_out_last;

    logic                  w_take;
    logic                  w_start;
    logic                  w_emit;
    logic                  w_last;
    logic                  w_pos;
    logic                  w_move_x;
    logic                  w_move_y;
    logic [DW-1:0]         w_minor2;
    logic [DW-1:0]         w_diff2;
    logic [COORD_BITS-1:0] w_rem_dec;

    assign w_cmd       = t_cmd'(i_cmd);
    assign o_cmd_ready = !r_out_valid || o_pix.ready;
    assign w_take      = i_cmd_valid && o_cmd_ready;
    assign w_start     = w_cmd.op == OP_START;
    // a step with no line in progress is dropped without a pixel
    assign w_emit      = w_start || r_active;

    assign w_pos     = !r_decision[DW-1] && (r_decision != '0);
    assign w_move_x  = r_steep ? w_pos : 1'b1;
    assign w_move_y  = r_steep ? 1'b1 : w_pos;
    assign w_minor2  = {1'b0, r_minor, 1'b0};
    assign w_diff2   = {1'b0, r_minor, 1'b0} - {1'b0, r_major, 1'b0};
    assign w_rem_dec = r_remaining - 1'b1;
    assign w_last    = w_start ? (w_cmd.major == '0) : (w_rem_dec == '0);

    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_decision  = r_decision;
        n_major     = r_major;
        n_minor     = r_minor;
        n_x_dir     = r_x_dir;
        n_y_dir     = r_y_dir;
        n_steep     = r_steep;
        n_remaining = r_remaining;
        n_active    = r_active;
        if (w_take) begin
            if (w_start) begin
                n_cur_x     = w_cmd.x0;
                n_cur_y     = w_cmd.y0;
                n_decision  = w_cmd.decision;
                n_major     = w_cmd.major;
                n_minor     = w_cmd.minor;
                n_x_dir     = w_cmd.x_dir;
                n_y_dir     = w_cmd.y_dir;
                n_steep     = w_cmd.steep;
                n_remaining = w_cmd.major;
                n_active    = w_cmd.major != '0;
            end else if (r_active) begin
                if (w_move_x) begin
                    n_cur_x = r_x_dir ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                end
                if (w_move_y) begin
                    n_cur_y = r_y_dir ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                end
                n_decision  = r_decision + (w_pos ? w_diff2 : w_minor2);
                n_remaining = w_rem_dec;
                n_active    = w_rem_dec != '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x     <= n_cur_x;
        r_cur_y     <= n_cur_y;
        r_decision  <= n_decision;
        r_major     <= n_major;
        r_minor     <= n_minor;
        r_x_dir     <= n_x_dir;
        r_y_dir     <= n_y_dir;
        r_steep     <= n_steep;
        r_remaining <= n_remaining;
        if (w_take && w_emit) begin
            r_out_x    <= n_cur_x;
            r_out_y    <= n_cur_y;
            r_out_last <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            if (w_take && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_x    = r_out_x;
    assign o_pix.pixel_y    = r_out_y;
    assign o_pix.last_pixel = r_out_last;

`ifndef ASSERT_OFF
    a_active_has_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_remaining != '0))
        else $error("line active with no pixels remaining");

    a_emit_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_emit) |=> r_out_valid)
        else $error("emitted pixel did not reach output register");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_emit && w_last) |=> !r_active)
        else $error("line still active after its last pixel");

    a_drop_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_emit && !r_out_valid) |=> !r_out_valid)
        else $error("pixel produced by a step with no line");
`endif

endmodule

`default_nettype wire

[src/bresenham_line_stepper.sv]
// bresenham line stepper top level: front end, command queue, stepper
// depends on blsp_pkg, blsp_if, blsp_front, blsp_fifo and blsp_back
// an accepted beat is registered in the queue, then stepped into the output register;
//   its pixel is then held on o_pix until taken
// throughput: one item per cycle while o_pix is ready, else the stepper stalls;
//   reset (sync, active low) empties the queue, drops the line, clears valid, ready stays high

`default_nettype none

module bresenham_line_stepper
    import blsp_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    blsp_in_if.sink     i_in,
    blsp_pix_if.source  o_pix
);

    // one queued command: classified start item or plain step request
    localparam int CMD_W = cmd_width(COORD_BITS);

    logic             w_front_valid;
    logic             w_front_ready;
    logic [CMD_W-1:0] w_front_cmd;
    logic             w_q_valid;
    logic             w_q_ready;
    logic [CMD_W-1:0] w_q_cmd;

    // front end: octant, axis lengths and initial decision term for start beats
    blsp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_in        (i_in),
        .o_cmd_valid (w_front_valid),
        .i_cmd_ready (w_front_ready),
        .o_cmd       (w_front_cmd)
    );

    // two-entry queue so input and output stalls stay independent
    // once an output stall fills it, input ready returns the cycle after the next pop
    blsp_fifo #(
        .WIDTH (CMD_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid && w_front_ready),
        .i_data  (w_front_cmd),
        .o_ready (w_front_ready),
        .o_valid (w_q_valid),
        .o_data  (w_q_cmd),
        .i_pop   (w_q_valid && w_q_ready)
    );

    // stepper: holds line state, emits one pixel per start or active-line step into an output register
    blsp_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (w_q_cmd),
        .o_pix       (o_pix)
    );

endmodule

`default_nettype wire
